>>> sv/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

>>> sv/lps_pkg.sv
package lps_pkg;

	// Operation codes of a command transaction.
	typedef enum logic [1:0] {
		OP_TICK        = 2'd0,
		OP_SET_PATTERN = 2'd1,
		OP_SET_MODE    = 2'd2,
		OP_PULSE       = 2'd3
	} op_t;

	// Mode presets.
	localparam logic [2:0] MODE_OFF   = 3'd0;
	localparam logic [2:0] MODE_ON    = 3'd1;
	localparam logic [2:0] MODE_BLINK = 3'd2;
	localparam logic [2:0] MODE_SLOW  = 3'd3;
	localparam logic [2:0] MODE_FAST  = 3'd4;
	localparam logic [2:0] MODE_FLASH = 3'd5;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LEVEL    = 2'd1;

	// Reset values.
	localparam logic [15:0] SLOT_INTERVAL_RESET = 16'd100;
	localparam logic [15:0] SLOT_COUNT_RESET    = 16'd100;

	typedef struct packed {
		op_t         op;
		logic [31:0] pattern_word;
		logic [2:0]  mode;
		logic [15:0] duration;
	} cmd_t;

	typedef struct packed {
		logic led_pin;
		logic pulse_busy;
	} res_t;

	// 32-bit preset word for a mode; unknown modes are off.
	function automatic logic [31:0] preset_word(input logic [2:0] mode);
		logic [31:0] w;
		unique case (mode)
			MODE_ON:    w = 32'hffff_ffff;
			MODE_BLINK: w = 32'hf0f0_f0f0;
			MODE_SLOW:  w = 32'hffff_0000;
			MODE_FAST:  w = 32'haaaa_aaaa;
			MODE_FLASH: w = 32'h8000_0000;
			default:    w = 32'h0000_0000;
		endcase
		return w;
	endfunction

endpackage

>>> sv/lps_cmd_if.sv
interface lps_cmd_if;
	logic             valid;
	logic             ready;
	lps_pkg::op_t     op;
	logic [31:0]      pattern_word;
	logic [2:0]       mode;
	logic [15:0]      duration;

	modport source (output valid, op, pattern_word, mode, duration, input ready);
	modport sink (input valid, op, pattern_word, mode, duration, output ready);
endinterface

>>> sv/lps_res_if.sv
interface lps_res_if;
	logic valid;
	logic ready;
	logic led_pin;
	logic pulse_busy;

	modport source (output valid, led_pin, pulse_busy, input ready);
	modport sink (input valid, led_pin, pulse_busy, output ready);
endinterface

>>> sv/lps_in_stage.sv
module lps_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  lps_pkg::cmd_t cmd_data,
	output logic          cmd_ready,
	input  logic          advance,
	output logic          valid_s1,
	output lps_pkg::cmd_t cmd_s1
);

	// The stage takes a new transaction when empty or when its item moves on.
	assign cmd_ready = !valid_s1 || advance;

	// Valid flag of the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	// Payload of the input register.
	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			cmd_s1 <= cmd_data;
		end
	end

endmodule

>>> sv/lps_engine.sv
module lps_engine #(
	parameter int PATTERN_BITS     = 32,
	parameter int PULSE_SLOT_TICKS = 100
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lps_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             valid_s1,
	input  lps_pkg::cmd_t                    cmd_s1,
	output logic                             advance,
	output logic                             res_valid,
	input  logic                             res_ready,
	output lps_pkg::res_t                    res_data
);

	localparam logic [PATTERN_BITS-1:0] TOP_BIT = {1'b1, {(PATTERN_BITS-1){1'b0}}};
	localparam logic [15:0] PULSE_SLOT = 16'(PULSE_SLOT_TICKS);

	logic [15:0]             slot_interval_q;
	logic                    idle_level_q;
	logic [PATTERN_BITS-1:0] pattern_q;
	logic [PATTERN_BITS-1:0] selector_q;
	logic [15:0]             slot_count_q;
	logic [15:0]             pulse_count_q;
	logic                    pulse_on_q;
	logic                    pin_q;

	logic [PATTERN_BITS-1:0] pattern_d;
	logic [PATTERN_BITS-1:0] selector_d;
	logic [15:0]             slot_count_d;
	logic [15:0]             pulse_count_d;
	logic                    pulse_on_d;
	logic                    pin_d;

	logic [PATTERN_BITS+31:0] preset_wide;
	logic [PATTERN_BITS+31:0] word_wide;
	logic [PATTERN_BITS-1:0]  new_pattern;
	logic [PATTERN_BITS-1:0]  cur_sel;
	logic [15:0]              pulse_dec;
	logic [15:0]              slot_dec;
	logic                     process;

	// An item is processed when the result register is free or being emptied.
	assign advance = !res_valid || res_ready;
	assign process = valid_s1 && advance;

	// Presets are aligned to the top of the pattern; direct words keep their low bits.
	assign preset_wide = {lps_pkg::preset_word(cmd_s1.mode), {PATTERN_BITS{1'b0}}};
	assign word_wide   = {{PATTERN_BITS{1'b0}}, cmd_s1.pattern_word};
	assign new_pattern = (cmd_s1.op == lps_pkg::OP_SET_MODE) ?
		preset_wide[PATTERN_BITS+31:32] : word_wide[PATTERN_BITS-1:0];

	assign pulse_dec = (pulse_count_q != 16'd0) ? pulse_count_q - 16'd1 : pulse_count_q;
	assign slot_dec  = (slot_count_q != 16'd0) ? slot_count_q - 16'd1 : slot_count_q;
	assign cur_sel   = (selector_q == '0) ? TOP_BIT : selector_q;

	// Next state for one command.
	always_comb begin
		pattern_d     = pattern_q;
		selector_d    = selector_q;
		slot_count_d  = slot_count_q;
		pulse_count_d = pulse_count_q;
		pulse_on_d    = pulse_on_q;
		pin_d         = pin_q;
		unique case (cmd_s1.op)
			lps_pkg::OP_TICK: begin
				// Pulse expiry comes before the slot step.
				if (pulse_on_q) begin
					pulse_count_d = pulse_dec;
					if (pulse_dec == 16'd0) begin
						pin_d      = idle_level_q;
						pulse_on_d = 1'b0;
					end
				end
				slot_count_d = slot_dec;
				if (slot_dec == 16'd0) begin
					if (pulse_on_d) begin
						slot_count_d = PULSE_SLOT;
					end else begin
						pin_d        = (|(pattern_q & cur_sel)) ? !idle_level_q : idle_level_q;
						selector_d   = cur_sel >> 1;
						slot_count_d = (slot_interval_q == 16'd0) ? 16'd1 : slot_interval_q;
					end
				end
			end
			lps_pkg::OP_SET_PATTERN, lps_pkg::OP_SET_MODE: begin
				// A different pattern restarts the walk at the top bit.
				if (new_pattern != pattern_q) begin
					pattern_d  = new_pattern;
					selector_d = '0;
				end
			end
			lps_pkg::OP_PULSE: begin
				if (!pulse_on_q) begin
					pin_d      = !idle_level_q;
					pulse_on_d = 1'b1;
				end
				pulse_count_d = (cmd_s1.duration == 16'd0) ? 16'd1 : cmd_s1.duration;
			end
			default: begin
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_interval_q <= lps_pkg::SLOT_INTERVAL_RESET;
			idle_level_q    <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == lps_pkg::CFG_SLOT_INTERVAL) begin
				slot_interval_q <= cfg_data;
			end else if (cfg_index == lps_pkg::CFG_IDLE_LEVEL) begin
				idle_level_q <= cfg_data[0];
			end
		end
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q     <= '0;
			selector_q    <= '0;
			slot_count_q  <= lps_pkg::SLOT_COUNT_RESET;
			pulse_count_q <= 16'd0;
			pulse_on_q    <= 1'b0;
			pin_q         <= 1'b0;
		end else if (process) begin
			pattern_q     <= pattern_d;
			selector_q    <= selector_d;
			slot_count_q  <= slot_count_d;
			pulse_count_q <= pulse_count_d;
			pulse_on_q    <= pulse_on_d;
			pin_q         <= pin_d;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (advance) begin
			res_valid <= valid_s1;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (process) begin
			res_data.led_pin    <= pin_d;
			res_data.pulse_busy <= pulse_on_d;
		end
	end

endmodule

>>> sv/led_pattern_sequencer.sv
// LED pattern sequencer.
// Commands arrive on the cmd channel (valid/ready); each accepted transaction
// is a tick, a new pattern, a mode preset or a pulse start. Every command gives
// exactly one result transaction on the res channel carrying the LED pin level
// and the pulse-busy flag after that command.
// Configuration: cfg_we with cfg_index 0 writes the slot interval, index 1 the
// idle level; other indices are ignored. Write only while the block is idle.
// A command passes the input register, then the result register, before its
// result is presented; the state update is a single pass of logic between the
// two registers. Throughput is one command per cycle while the receiver takes
// results.
// When the receiver stalls, the result register holds its transaction and the
// input register takes one more command; cmd.ready then drops until res moves.
// Reset (arst_n low) clears the pattern, stops any pulse, sets the slot
// countdown and interval to 100 and the idle level and pin to low.
module led_pattern_sequencer #(
	parameter int PATTERN_BITS     = 32,
	parameter int PULSE_SLOT_TICKS = 100
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lps_pkg::CFG_DATA_W-1:0] cfg_data,
	lps_cmd_if.sink                        cmd,
	lps_res_if.source                      res
);

	lps_pkg::cmd_t cmd_data;
	lps_pkg::cmd_t cmd_s1;
	lps_pkg::res_t res_data;
	logic          valid_s1;
	logic          advance;

	// Gather the command payload.
	assign cmd_data.op           = cmd.op;
	assign cmd_data.pattern_word = cmd.pattern_word;
	assign cmd_data.mode         = cmd.mode;
	assign cmd_data.duration     = cmd.duration;

	lps_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_data  (cmd_data),
		.cmd_ready (cmd.ready),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.cmd_s1    (cmd_s1)
	);

	lps_engine #(
		.PATTERN_BITS     (PATTERN_BITS),
		.PULSE_SLOT_TICKS (PULSE_SLOT_TICKS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.valid_s1  (valid_s1),
		.cmd_s1    (cmd_s1),
		.advance   (advance),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.res_data  (res_data)
	);

	// Drive the result payload.
	assign res.led_pin    = res_data.led_pin;
	assign res.pulse_busy = res_data.pulse_busy;

endmodule

>>> sv/lps_checker.sv
`include "assert_macros.svh"

module lps_checker (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input logic res_valid,
	input logic res_ready,
	input logic res_led_pin,
	input logic res_pulse_busy
);

	// A stalled result transaction holds its payload.
	`ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_led_pin) && $stable(res_pulse_busy))

	// Commands are refused only while a result is stalled.
	`ASSERT_IMPL(a_ready_only_stall, clk, arst_n, !cmd_ready, res_valid && !res_ready)

	// A result appearing on an empty channel comes from an accepted command that passed the input register.
	`ASSERT_IMPL(a_res_has_cmd, clk, arst_n, $rose(res_valid), $past(cmd_valid && cmd_ready, 2))

endmodule

bind led_pattern_sequencer lps_checker u_lps_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.res_led_pin    (res.led_pin),
	.res_pulse_busy (res.pulse_busy)
);
